// ===== hdl/srmt_pkg.sv =====
`default_nettype none
package srmt_pkg;

  localparam int KEY_W   = 64;
  localparam int NCELLS  = 6;
  localparam int CELLS_W = 2 * NCELLS;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_TOUCH  = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  localparam logic [2:0] CELL_INT = 3'd0;
  localparam logic [2:0] CELL_II  = 3'd1;
  localparam logic [2:0] CELL_EI  = 3'd2;
  localparam logic [2:0] CELL_IE  = 3'd3;
  localparam logic [2:0] CELL_EB  = 3'd4;
  localparam logic [2:0] CELL_BE  = 3'd5;

  localparam logic [2:0] PRED_EQUALS     = 3'd0;
  localparam logic [2:0] PRED_MEETS      = 3'd1;
  localparam logic [2:0] PRED_CONTAINS   = 3'd2;
  localparam logic [2:0] PRED_COVERS     = 3'd3;
  localparam logic [2:0] PRED_INTERSECTS = 3'd4;
  localparam logic [2:0] PRED_WITHIN     = 3'd5;
  localparam logic [2:0] PRED_COVERED_BY = 3'd6;
  localparam logic [2:0] PRED_DISJOINT   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RESP,
    ST_QUERY,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic               key_hit;
    logic               pred_hit;
    logic [CELLS_W-1:0] merged;
  } eval_res_t;

  function automatic logic cell_set(input logic [CELLS_W-1:0] m, input logic [2:0] c);
    cell_set = (m[2*c +: 2] != 2'd0);
  endfunction

  function automatic logic pred_holds(input logic [2:0] p, input logic [CELLS_W-1:0] m);
    logic in_s, ii, ei, ie, eb, be;
    in_s = cell_set(m, CELL_INT);
    ii   = cell_set(m, CELL_II);
    ei   = cell_set(m, CELL_EI);
    ie   = cell_set(m, CELL_IE);
    eb   = cell_set(m, CELL_EB);
    be   = cell_set(m, CELL_BE);
    case (p)
      PRED_EQUALS:     pred_holds = ii && !ie && !be && !ei && !eb;
      PRED_MEETS:      pred_holds = in_s && !ii;
      PRED_CONTAINS:   pred_holds = ii && !ei && !eb;
      PRED_COVERS:     pred_holds = in_s && !ei && !eb;
      PRED_INTERSECTS: pred_holds = in_s;
      PRED_WITHIN:     pred_holds = ii && !ie && !be;
      PRED_COVERED_BY: pred_holds = in_s && !ie && !be;
      default:         pred_holds = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/srmt_store.sv =====
`default_nettype none
module srmt_store
  import srmt_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire logic [KEY_W-1:0]   wkey,
  input  wire logic [CELLS_W-1:0] wcells,
  input  wire logic               re,
  input  wire logic [IDX_W-1:0]   raddr,
  output logic      [KEY_W-1:0]   rkey,
  output logic      [CELLS_W-1:0] rcells
);

  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [CELLS_W-1:0] cells_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]   <= wkey;
      cells_mem[waddr] <= wcells;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rkey   <= key_mem[raddr];
      rcells <= cells_mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/srmt_eval.sv =====
`default_nettype none
module srmt_eval
  import srmt_pkg::*;
(
  input  wire logic [KEY_W-1:0]   slot_key,
  input  wire logic [CELLS_W-1:0] slot_cells,
  input  wire logic [KEY_W-1:0]   req_key,
  input  wire logic [1:0]         req_kind,
  input  wire logic [2:0]         req_cell,
  input  wire logic [1:0]         req_dim,
  input  wire logic [2:0]         req_pred,
  output eval_res_t               res
);

  logic [1:0] nv;

  always_comb begin
    nv = (req_dim == 2'd3) ? 2'd3 : req_dim + 2'd1;
    res.key_hit  = (slot_key == req_key);
    res.pred_hit = pred_holds(req_pred, slot_cells);
    res.merged   = slot_cells;
    for (int c = 0; c < NCELLS; c++) begin
      if (req_kind == KIND_UPDATE && req_cell == 3'(c) && nv > slot_cells[2*c +: 2]) begin
        res.merged[2*c +: 2] = nv;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spatial_relation_matrix_table.sv =====
`default_nettype none
// Table of geometry ids, each with six 2-bit intersection-matrix cells. An update
// or touch item scans the stored ids one slot per cycle for its key, then raises
// the addressed cell (update only) or inserts the id, and returns one echo item
// (status 1 when the table is full and the id is new). A query item scans all stored
// slots one per cycle, pausing while a match waits on a busy output register, and
// returns every id whose cells satisfy the predicate, in store order, tlast on the
// final one; no match gives no result. The single read port of the slot store, one
// slot per cycle, paces each scan over the used slots; output back-pressure adds to
// that. in_tready is low while an item is in progress; its final result may still
// sit in the output register when the next item is accepted.
module spatial_relation_matrix_table
  import srmt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // entry_id[63:0], cell_req[66:64], dimension[68:67],
                                       // predicate[71:69]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // result_id[63:0]
  output logic [1:0]       out_tuser,  // matched[0], status[1]
  output logic             out_tlast
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  state_t state_r, state_nxt;

  logic [KEY_W-1:0]  req_key_r;
  logic [1:0]        req_kind_r;
  logic [2:0]        req_cell_r;
  logic [1:0]        req_dim_r;
  logic [2:0]        req_pred_r;

  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              status_r, status_nxt;
  logic [KEY_W-1:0]  pend_key_r, pend_key_nxt;
  logic              pend_vld_r, pend_vld_nxt;

  logic              out_vld_r;
  logic [KEY_W-1:0]  out_key_r;
  logic              out_match_r, out_stat_r, out_last_r;
  logic              load;
  logic [KEY_W-1:0]  load_key;
  logic              load_match, load_stat, load_last;

  logic              we, re, issue, stall, scan_more, out_free, accept;
  logic [IDX_W-1:0]  waddr;
  logic [KEY_W-1:0]  rd_key;
  logic [CELLS_W-1:0] rd_cells, ev_cells;
  eval_res_t         ev;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_vld_r || out_tready;
  assign scan_more = (scan_r < used_r);
  assign ev_cells  = rd_vld_r ? rd_cells : '0;
  assign re        = issue;

  srmt_store #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wkey   (req_key_r),
    .wcells (ev.merged),
    .re     (re),
    .raddr  (scan_r[IDX_W-1:0]),
    .rkey   (rd_key),
    .rcells (rd_cells)
  );

  srmt_eval u_eval (
    .slot_key   (rd_key),
    .slot_cells (ev_cells),
    .req_key    (req_key_r),
    .req_kind   (req_kind_r),
    .req_cell   (req_cell_r),
    .req_dim    (req_dim_r),
    .req_pred   (req_pred_r),
    .res        (ev)
  );

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    scan_nxt     = scan_r;
    rd_idx_nxt   = rd_idx_r;
    rd_vld_nxt   = rd_vld_r;
    status_nxt   = status_r;
    pend_key_nxt = pend_key_r;
    pend_vld_nxt = pend_vld_r;
    we           = 1'b0;
    waddr        = rd_idx_r;
    issue        = 1'b0;
    stall        = 1'b0;
    load         = 1'b0;
    load_key     = req_key_r;
    load_match   = 1'b0;
    load_stat    = 1'b0;
    load_last    = 1'b1;

    if (state_r == ST_QUERY) begin
      stall = rd_vld_r && ev.pred_hit && pend_vld_r && !out_free;
    end
    if ((state_r == ST_LOOK || state_r == ST_QUERY) && !stall) begin
      issue      = scan_more;
      rd_vld_nxt = scan_more;
      if (scan_more) begin
        rd_idx_nxt = scan_r[IDX_W-1:0];
        scan_nxt   = scan_r + CNT_W'(1);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          scan_nxt     = '0;
          rd_vld_nxt   = 1'b0;
          pend_vld_nxt = 1'b0;
          case (kind_t'(in_tuser))
            KIND_UPDATE, KIND_TOUCH: state_nxt = ST_LOOK;
            KIND_QUERY:              state_nxt = ST_QUERY;
            default:                 state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: begin
        if (rd_vld_r && ev.key_hit) begin
          we         = 1'b1;
          status_nxt = 1'b0;
          state_nxt  = ST_RESP;
        end else if (!rd_vld_r && !scan_more) begin
          if (used_r == CNT_W'(ENTRIES)) begin
            status_nxt = 1'b1;
          end else begin
            we         = 1'b1;
            waddr      = used_r[IDX_W-1:0];
            used_nxt   = used_r + CNT_W'(1);
            status_nxt = 1'b0;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          load      = 1'b1;
          load_stat = status_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (rd_vld_r && ev.pred_hit && !stall) begin
          if (pend_vld_r) begin
            load       = 1'b1;
            load_key   = pend_key_r;
            load_match = 1'b1;
            load_last  = 1'b0;
          end
          pend_key_nxt = rd_key;
          pend_vld_nxt = 1'b1;
        end else if (!rd_vld_r && !scan_more) begin
          state_nxt = pend_vld_r ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          load       = 1'b1;
          load_key   = pend_key_r;
          load_match = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      used_r     <= '0;
      rd_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      rd_vld_r   <= rd_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    rd_idx_r   <= rd_idx_nxt;
    status_r   <= status_nxt;
    pend_key_r <= pend_key_nxt;
    if (accept) begin
      req_key_r  <= in_tdata[63:0];
      req_cell_r <= in_tdata[66:64];
      req_dim_r  <= in_tdata[68:67];
      req_pred_r <= in_tdata[71:69];
      req_kind_r <= in_tuser;
    end
    if (load) begin
      out_key_r   <= load_key;
      out_match_r <= load_match;
      out_stat_r  <= load_stat;
      out_last_r  <= load_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_key_r;
  assign out_tuser  = {out_stat_r, out_match_r};
  assign out_tlast  = out_last_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(ENTRIES))
    else $error("slot count beyond table size");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (used_r == $past(used_r) || used_r == $past(used_r) + CNT_W'(1)))
    else $error("slot count moved by more than one");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stat_r) |-> (used_r == CNT_W'(ENTRIES)))
    else $error("full status while table has room");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_match_r) |-> !out_stat_r)
    else $error("query result flagged full");

endmodule
`default_nettype wire
